// ----- rtl/mbgm_pkg.sv -----
// ----------------------------------------------------------------------------
// mbgm_pkg
// shared constants, types and coefficient tables for the master bus gain,
// meter and clip unit
// ----------------------------------------------------------------------------
package mbgm_pkg;

    localparam int SUM_WIDTH_DEF    = 40;
    localparam int BLOCK_FRAMES_DEF = 64;
    localparam int METER_STRIDE_DEF = 4;

    localparam int PEAK_W      = 41;
    localparam int OUT_W       = 32;
    localparam int GAIN_W      = 17;
    localparam int VOL_W       = 7;
    localparam int MODE_W      = 3;
    localparam int DAMP_W      = 25;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int STEP_W      = 4;
    localparam int IDX_W       = 3;
    localparam int FLAG_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int MUL_A_W     = 34;
    localparam int MUL_B_W     = 26;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int SOFT_W      = 34;

    localparam logic [PEAK_W-1:0] PEAK_MAX   = {PEAK_W{1'b1}};
    localparam logic [PEAK_W-1:0] PEAK_FLOOR = 41'd2147484;

    localparam logic signed [SOFT_W-1:0] HARD_POS = 34'sd1073709056;
    localparam logic signed [SOFT_W-1:0] HARD_NEG = -34'sd1073741824;

    localparam logic [DAMP_W-1:0] DAMP_ONE = 25'd16777216;
    localparam logic [DAMP_W-1:0] DAMP_MAX = 25'd33554431;

    localparam logic [23:0] THIRD_RECIP = 24'd11184811;
    localparam logic [15:0] MX_POS      = 16'd32767;
    localparam logic [15:0] MX_NEG      = 16'd32768;

    localparam logic [GAIN_W-1:0] GAIN_RST = 17'd32768;
    localparam logic [VOL_W-1:0]  VOL_RST  = 7'd100;

    localparam logic [MODE_W-1:0] SOFT_MIN = 3'd1;
    localparam logic [MODE_W-1:0] SOFT_MAX = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_VOLUME = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOFT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_COMP   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BYPASS = 3'd4;

    // sequencer step codes
    localparam logic [STEP_W-1:0] ST_GAIN_LO = 4'd0;
    localparam logic [STEP_W-1:0] ST_GAIN_HI = 4'd1;
    localparam logic [STEP_W-1:0] ST_ABS     = 4'd2;
    localparam logic [STEP_W-1:0] ST_DAMP_LO = 4'd3;
    localparam logic [STEP_W-1:0] ST_DAMP_HI = 4'd4;
    localparam logic [STEP_W-1:0] ST_CLAMP   = 4'd5;
    localparam logic [STEP_W-1:0] ST_DIV0    = 4'd6;
    localparam logic [STEP_W-1:0] ST_DIV1    = 4'd7;
    localparam logic [STEP_W-1:0] ST_X       = 4'd8;
    localparam logic [STEP_W-1:0] ST_XX      = 4'd9;
    localparam logic [STEP_W-1:0] ST_X3      = 4'd10;
    localparam logic [STEP_W-1:0] ST_DIV3    = 4'd11;
    localparam logic [STEP_W-1:0] ST_POLY    = 4'd12;
    localparam logic [STEP_W-1:0] ST_COMP    = 4'd13;
    localparam logic [STEP_W-1:0] ST_FINAL   = 4'd14;
    localparam logic [STEP_W-1:0] ST_DONE    = 4'd15;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [DAMP_W-1:0] damp;
        logic [MODE_W-1:0] soft_mode;
        logic              gain_comp;
        logic              bypass;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic [STEP_W-1:0] step;
    } t_lane_ctl;

    typedef struct packed {
        logic last_frame;
        logic sample;
        logic closed;
    } t_flags;

    typedef logic [DAMP_W-1:0] t_damp_tab [2**VOL_W];

    // damp = (volume/100)^4 in q1.24, saturated
    function automatic t_damp_tab build_damp_tab();
        t_damp_tab         tab;
        longint unsigned   p;
        for (int v = 0; v < 2**VOL_W; v++) begin
            p = 64'(v);
            p = p * p * p * p;
            p = (p << 24) / 64'd100000000;
            if (p > 64'(DAMP_MAX)) begin
                p = 64'(DAMP_MAX);
            end
            tab[v] = p[DAMP_W-1:0];
        end
        return tab;
    endfunction

    localparam t_damp_tab DAMP_TAB = build_damp_tab();

    function automatic logic [23:0] alpha_q22(input logic [1:0] k);
        logic [23:0] r;
        unique case (k)
            2'd0: r = 24'd6081741;
            2'd1: r = 24'd4487905;
            2'd2: r = 24'd3145728;
            2'd3: r = 24'd2222981;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] alpha_inv_q22(input logic [1:0] k);
        logic [23:0] r;
        unique case (k)
            2'd0: r = 24'd2892623;
            2'd1: r = 24'd3919910;
            2'd2: r = 24'd5592405;
            2'd3: r = 24'd7913781;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] alpha23_q22(input logic [1:0] k);
        logic [23:0] r;
        unique case (k)
            2'd0: r = 24'd4054494;
            2'd1: r = 24'd2991937;
            2'd2: r = 24'd2097152;
            2'd3: r = 24'd1481987;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] gc_q22(input logic [1:0] k);
        logic [23:0] r;
        unique case (k)
            2'd0: r = 24'd4984564;
            2'd1: r = 24'd5917023;
            2'd2: r = 24'd8388608;
            2'd3: r = 24'd11870672;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/mbgm_front.sv -----
// ----------------------------------------------------------------------------
// mbgm_front
// takes input beats, tags each frame with its meter sample and block close
// ----------------------------------------------------------------------------
module mbgm_front import mbgm_pkg::*; #(
    parameter int SUM_WIDTH    = SUM_WIDTH_DEF,
    parameter int BLOCK_FRAMES = BLOCK_FRAMES_DEF,
    parameter int METER_STRIDE = METER_STRIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SUM_WIDTH-1:0] i_left_sum,
    input  logic signed [SUM_WIDTH-1:0] i_right_sum,
    input  logic                        i_last_frame,
    input  logic                        i_full,
    output logic                        o_push,
    output logic [2*SUM_WIDTH+FLAG_W-1:0] o_data
);

    localparam int POS_W   = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
    localparam int PHASE_W = (METER_STRIDE > 1) ? $clog2(METER_STRIDE) : 1;

    logic [POS_W-1:0]   r_pos;
    logic [PHASE_W-1:0] r_phase;
    t_flags             flags;
    logic               accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        flags.last_frame = i_last_frame;
        flags.sample     = (r_phase == '0);
        flags.closed     = i_last_frame || (r_pos == POS_W'(BLOCK_FRAMES - 1));
    end

    assign o_data = {i_left_sum, i_right_sum, flags};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
        end else if (accept) begin
            if (flags.closed) begin
                r_pos   <= '0;
                r_phase <= '0;
            end else begin
                r_pos   <= r_pos + POS_W'(1);
                r_phase <= (r_phase == PHASE_W'(METER_STRIDE - 1)) ? '0
                                                                   : r_phase + PHASE_W'(1);
            end
        end
    end

endmodule

// ----- rtl/mbgm_queue.sv -----
// ----------------------------------------------------------------------------
// mbgm_queue
// short first-in first-out queue between the front and the back
// ----------------------------------------------------------------------------
module mbgm_queue import mbgm_pkg::*; #(
    parameter int WIDTH = 2 * SUM_WIDTH_DEF + FLAG_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/mbgm_lane.sv -----
// ----------------------------------------------------------------------------
// mbgm_lane
// one channel of the datapath: gain, damp, clamp, soft clip and hard clip
// on a single shared multiplier, one step per cycle
// ----------------------------------------------------------------------------
module mbgm_lane import mbgm_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  t_lane_ctl                   i_ctl,
    input  t_cfg                        i_cfg,
    input  logic signed [SUM_WIDTH-1:0] i_sum,
    output logic [PEAK_W-1:0]           o_peak,
    output logic signed [OUT_W-1:0]     o_out,
    output logic                        o_clip
);

    localparam int ACC_W = SUM_WIDTH + 18;
    localparam int MAG_W = SUM_WIDTH + 3;
    localparam int PRD_W = SUM_WIDTH + 4;

    logic signed [SUM_WIDTH-1:0] r_v;
    logic signed [ACC_W-1:0]     r_acc;
    logic                        r_neg;
    logic [MAG_W-1:0]            r_m;
    logic [PRD_W-1:0]            r_p;
    logic [PEAK_W-1:0]           r_peak;
    logic signed [OUT_W-1:0]     r_c;
    logic [OUT_W-1:0]            r_a;
    logic                        r_cneg;
    logic [23:0]                 r_q;
    logic [23:0]                 r_u;
    logic [24:0]                 r_x;
    logic [21:0]                 r_xx;
    logic [21:0]                 r_x3;
    logic [21:0]                 r_d3;
    logic [24:0]                 r_f;
    logic signed [OUT_W-1:0]     r_out;
    logic                        r_clip;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   prod;
    logic [1:0]                  k;
    logic                        soft_on;
    logic signed [MAG_W-1:0]     s_gain;
    logic [MAG_W-1:0]            s_abs;
    logic                        big;
    logic [39:0]                 n;
    logic [39:0]                 nsum;
    logic [39:0]                 rem;
    logic [23:0]                 u_pos;
    logic [32:0]                 soft_mag;
    logic signed [SOFT_W-1:0]    soft_val;
    logic signed [SOFT_W-1:0]    base;

    assign k       = 2'(i_cfg.soft_mode - 3'd1);
    assign soft_on = (i_cfg.soft_mode >= SOFT_MIN) && (i_cfg.soft_mode <= SOFT_MAX);

    assign s_gain = MAG_W'(r_acc >>> 15);
    assign s_abs  = s_gain[MAG_W-1] ? MAG_W'(-s_gain) : MAG_W'(s_gain);
    assign big    = (64'(r_p) >= 64'h8000_0000);

    // positive magnitude over 32767, using 2^15 = 1 mod 32767
    assign n     = {1'b0, r_a, 7'b0};
    assign nsum  = n + (n >> 15) + (n >> 30);
    assign rem   = n - {1'b0, r_q, 15'b0} + 40'(r_q);
    assign u_pos = r_q + 24'(rem >= 40'd32767);

    assign soft_mag = prod[39:7];
    assign soft_val = r_cneg ? -$signed({1'b0, soft_mag}) : $signed({1'b0, soft_mag});
    assign base     = soft_on ? soft_val : SOFT_W'(r_c);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_ctl.step)
            ST_GAIN_LO: begin
                mul_a = $signed(MUL_A_W'(r_v[19:0]));
                mul_b = $signed(MUL_B_W'(i_cfg.gain));
            end
            ST_GAIN_HI: begin
                mul_a = MUL_A_W'($signed(r_v[SUM_WIDTH-1:20]));
                mul_b = $signed(MUL_B_W'(i_cfg.gain));
            end
            ST_DAMP_LO: begin
                mul_a = $signed(MUL_A_W'(r_m[23:0]));
                mul_b = $signed(MUL_B_W'(i_cfg.damp));
            end
            ST_DAMP_HI: begin
                mul_a = $signed(MUL_A_W'(r_m[MAG_W-1:24]));
                mul_b = $signed(MUL_B_W'(i_cfg.damp));
            end
            ST_X: begin
                mul_a = $signed(MUL_A_W'(r_u));
                mul_b = $signed(MUL_B_W'(alpha_inv_q22(k)));
            end
            ST_XX: begin
                mul_a = $signed(MUL_A_W'(r_x[21:0]));
                mul_b = $signed(MUL_B_W'(r_x[21:0]));
            end
            ST_X3: begin
                mul_a = $signed(MUL_A_W'(r_xx));
                mul_b = $signed(MUL_B_W'(r_x[21:0]));
            end
            ST_DIV3: begin
                mul_a = $signed(MUL_A_W'(r_x3));
                mul_b = $signed(MUL_B_W'(THIRD_RECIP));
            end
            ST_POLY: begin
                mul_a = $signed(MUL_A_W'(r_x[21:0] - r_d3));
                mul_b = $signed(MUL_B_W'(alpha_q22(k)));
            end
            ST_COMP: begin
                mul_a = $signed(MUL_A_W'(r_f));
                mul_b = $signed(MUL_B_W'(gc_q22(k)));
            end
            ST_FINAL: begin
                mul_a = $signed(MUL_A_W'(r_f));
                mul_b = $signed(MUL_B_W'(r_cneg ? MX_NEG : MX_POS));
            end
            ST_ABS, ST_CLAMP, ST_DIV0, ST_DIV1, ST_DONE: begin
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_sum;
        end else begin
            unique case (i_ctl.step)
                ST_GAIN_LO: r_acc <= ACC_W'(prod);
                ST_GAIN_HI: r_acc <= r_acc + (ACC_W'(prod) <<< 20);
                ST_ABS: begin
                    r_neg <= s_gain[MAG_W-1];
                    r_m   <= s_abs;
                end
                ST_DAMP_LO: r_p <= PRD_W'(prod[48:24]);
                ST_DAMP_HI: r_p <= r_p + prod[PRD_W-1:0];
                ST_CLAMP: begin
                    r_peak <= (64'(r_p) > 64'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(r_p);
                    r_cneg <= r_neg && (r_p != '0);
                    if (r_neg) begin
                        r_c <= big ? $signed(32'h8000_0000) : -$signed(r_p[31:0]);
                        r_a <= big ? 32'h8000_0000 : r_p[31:0];
                    end else begin
                        r_c <= big ? $signed(32'h7FFF_FFFF) : $signed(r_p[31:0]);
                        r_a <= big ? 32'h7FFF_FFFF : r_p[31:0];
                    end
                end
                ST_DIV0: r_q <= nsum[38:15];
                ST_DIV1: r_u <= r_cneg ? r_a[31:8] : u_pos;
                ST_X:    r_x <= prod[46:22];
                ST_XX:   r_xx <= prod[43:22];
                ST_X3:   r_x3 <= prod[43:22];
                ST_DIV3: r_d3 <= prod[46:25];
                ST_POLY: begin
                    // x at or past one sits on the flat top of the curve
                    r_f <= (r_x[24:22] != 3'd0) ? 25'(alpha23_q22(k)) : 25'(prod[44:22]);
                end
                ST_COMP: begin
                    if (i_cfg.gain_comp) begin
                        r_f <= prod[46:22];
                    end
                end
                ST_FINAL: begin
                    priority if (i_cfg.bypass) begin
                        r_out  <= r_c;
                        r_clip <= 1'b0;
                    end else if (base > HARD_POS) begin
                        r_out  <= OUT_W'(HARD_POS);
                        r_clip <= 1'b1;
                    end else if (base < HARD_NEG) begin
                        r_out  <= OUT_W'(HARD_NEG);
                        r_clip <= 1'b1;
                    end else begin
                        r_out  <= OUT_W'(base);
                        r_clip <= 1'b0;
                    end
                end
                ST_DONE: begin
                end
            endcase
        end
    end

    assign o_peak = r_peak;
    assign o_out  = r_out;
    assign o_clip = r_clip;

endmodule

// ----- rtl/mbgm_back.sv -----
// ----------------------------------------------------------------------------
// mbgm_back
// runs both channel lanes on one frame, then updates meters and clip flag
// and holds the result beat
// ----------------------------------------------------------------------------
module mbgm_back import mbgm_pkg::*; #(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  logic                        i_head_valid,
    input  logic signed [SUM_WIDTH-1:0] i_head_left,
    input  logic signed [SUM_WIDTH-1:0] i_head_right,
    input  t_flags                      i_head_flags,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_W-1:0]     o_left_out,
    output logic signed [OUT_W-1:0]     o_right_out,
    output logic                        o_clipped,
    output logic                        o_meter_valid,
    output logic [PEAK_W-1:0]           o_peak_left,
    output logic [PEAK_W-1:0]           o_peak_right,
    output logic                        o_end_of_buffer
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    t_flags            r_flags;
    logic [PEAK_W-1:0] r_blk_l;
    logic [PEAK_W-1:0] r_blk_r;
    logic [PEAK_W-1:0] r_held_l;
    logic [PEAK_W-1:0] r_held_r;
    logic              r_clip_seen;
    logic              r_out_valid;

    logic signed [OUT_W-1:0] r_left_out;
    logic signed [OUT_W-1:0] r_right_out;
    logic                    r_clipped;
    logic                    r_meter_valid;
    logic [PEAK_W-1:0]       r_peak_left;
    logic [PEAK_W-1:0]       r_peak_right;
    logic                    r_eob;

    t_lane_ctl               lane_ctl;
    logic [PEAK_W-1:0]       pk_l;
    logic [PEAK_W-1:0]       pk_r;
    logic signed [OUT_W-1:0] out_l;
    logic signed [OUT_W-1:0] out_r;
    logic                    clip_l;
    logic                    clip_r;
    logic                    pop;
    logic                    commit;
    logic [PEAK_W-1:0]       blk_l;
    logic [PEAK_W-1:0]       blk_r;
    logic [PEAK_W-1:0]       n_held_l;
    logic [PEAK_W-1:0]       n_held_r;
    logic                    clip_now;

    function automatic logic [PEAK_W-1:0] hold(input logic [PEAK_W-1:0] held,
                                               input logic [PEAK_W-1:0] blk);
        logic [PEAK_W-1:0] h;
        h = held >> 1;
        if (blk >= held) begin
            h = blk;
        end else if (h < PEAK_FLOOR) begin
            h = '0;
        end
        return h;
    endfunction

    assign pop    = i_head_valid && !r_busy;
    assign commit = r_busy && (r_step == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_pop  = pop;

    assign lane_ctl.load = pop;
    assign lane_ctl.step = r_step;

    mbgm_lane #(.SUM_WIDTH(SUM_WIDTH)) u_lane_l (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_cfg  (i_cfg),
        .i_sum  (i_head_left),
        .o_peak (pk_l),
        .o_out  (out_l),
        .o_clip (clip_l)
    );

    mbgm_lane #(.SUM_WIDTH(SUM_WIDTH)) u_lane_r (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_cfg  (i_cfg),
        .i_sum  (i_head_right),
        .o_peak (pk_r),
        .o_out  (out_r),
        .o_clip (clip_r)
    );

    always_comb begin
        blk_l    = (r_flags.sample && (pk_l > r_blk_l)) ? pk_l : r_blk_l;
        blk_r    = (r_flags.sample && (pk_r > r_blk_r)) ? pk_r : r_blk_r;
        n_held_l = r_flags.closed ? hold(r_held_l, blk_l) : r_held_l;
        n_held_r = r_flags.closed ? hold(r_held_r, blk_r) : r_held_r;
        clip_now = r_clip_seen || clip_l || clip_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_DONE;
            r_blk_l     <= '0;
            r_blk_r     <= '0;
            r_held_l    <= '0;
            r_held_r    <= '0;
            r_clip_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_busy <= 1'b1;
                r_step <= ST_GAIN_LO;
            end else if (r_busy && (r_step != ST_DONE)) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (commit) begin
                r_busy      <= 1'b0;
                r_blk_l     <= r_flags.closed ? '0 : blk_l;
                r_blk_r     <= r_flags.closed ? '0 : blk_r;
                r_held_l    <= n_held_l;
                r_held_r    <= n_held_r;
                r_clip_seen <= r_flags.last_frame ? 1'b0 : clip_now;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_flags <= i_head_flags;
        end
        if (commit) begin
            r_left_out    <= out_l;
            r_right_out   <= out_r;
            r_clipped     <= clip_now;
            r_meter_valid <= r_flags.closed;
            r_peak_left   <= n_held_l;
            r_peak_right  <= n_held_r;
            r_eob         <= r_flags.last_frame;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_left_out;
    assign o_right_out     = r_right_out;
    assign o_clipped       = r_clipped;
    assign o_meter_valid   = r_meter_valid;
    assign o_peak_left     = r_peak_left;
    assign o_peak_right    = r_peak_right;
    assign o_end_of_buffer = r_eob;

endmodule

// ----- rtl/master_bus_gain_meter_clip_unit.sv -----
// sequencing: accepted input beats wait in the queue; each frame runs through the
//   per-channel sequencer, which runs sixteen steps on one shared multiplier per lane,
//   and a new frame is taken only after the previous result beat is committed
// reset: synchronous, active low; registers return to unity gain, full
//   volume, clip off, and meters, frame position and clip flag clear at once
// ----------------------------------------------------------------------------
// master_bus_gain_meter_clip_unit
// master bus gain and damp, sub-block peak meter, cubic soft clip and
// sticky hard clip for one stereo frame per beat
// ----------------------------------------------------------------------------
module master_bus_gain_meter_clip_unit import mbgm_pkg::*; #(
    parameter int SUM_WIDTH    = SUM_WIDTH_DEF,
    parameter int BLOCK_FRAMES = BLOCK_FRAMES_DEF,
    parameter int METER_STRIDE = METER_STRIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready,
    // frame input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SUM_WIDTH-1:0] i_left_sum,
    input  logic signed [SUM_WIDTH-1:0] i_right_sum,
    input  logic                        i_last_frame,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_W-1:0]     o_left_out,
    output logic signed [OUT_W-1:0]     o_right_out,
    output logic                        o_clipped,
    output logic                        o_meter_valid,
    output logic [PEAK_W-1:0]           o_peak_left,
    output logic [PEAK_W-1:0]           o_peak_right,
    output logic                        o_end_of_buffer
);

    localparam int ITEM_W = 2 * SUM_WIDTH + FLAG_W;

    // control registers; damp follows volume through a constant table
    logic [GAIN_W-1:0] r_gain;
    logic [VOL_W-1:0]  r_volume;
    logic [DAMP_W-1:0] r_damp;
    logic [MODE_W-1:0] r_soft_mode;
    logic              r_gain_comp;
    logic              r_bypass;

    logic              wr_en;
    logic [IDX_W-1:0]  reg_idx;
    t_cfg              cfg;

    logic              q_full;
    logic              q_push;
    logic [ITEM_W-1:0] q_in;
    logic              q_valid;
    logic              q_pop;
    logic [ITEM_W-1:0] q_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RST;
            r_volume    <= VOL_RST;
            r_damp      <= DAMP_ONE;
            r_soft_mode <= '0;
            r_gain_comp <= 1'b0;
            r_bypass    <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GAIN:   r_gain <= pwdata[GAIN_W-1:0];
                REG_VOLUME: begin
                    r_volume <= pwdata[VOL_W-1:0];
                    r_damp   <= DAMP_TAB[pwdata[VOL_W-1:0]];
                end
                REG_SOFT:   r_soft_mode <= pwdata[MODE_W-1:0];
                REG_COMP:   r_gain_comp <= pwdata[0];
                REG_BYPASS: r_bypass <= pwdata[0];
                default: begin
                    // addresses past the register list are ignored
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAIN:   prdata = DATA_W'(r_gain);
            REG_VOLUME: prdata = DATA_W'(r_volume);
            REG_SOFT:   prdata = DATA_W'(r_soft_mode);
            REG_COMP:   prdata = DATA_W'(r_gain_comp);
            REG_BYPASS: prdata = DATA_W'(r_bypass);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        cfg.gain      = r_gain;
        cfg.damp      = r_damp;
        cfg.soft_mode = r_soft_mode;
        cfg.gain_comp = r_gain_comp;
        cfg.bypass    = r_bypass;
    end

    // front: frame position and meter stride tagging
    mbgm_front #(
        .SUM_WIDTH    (SUM_WIDTH),
        .BLOCK_FRAMES (BLOCK_FRAMES),
        .METER_STRIDE (METER_STRIDE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_left_sum   (i_left_sum),
        .i_right_sum  (i_right_sum),
        .i_last_frame (i_last_frame),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_data       (q_in)
    );

    // decouples input acceptance from the sequenced datapath
    mbgm_queue #(.WIDTH(ITEM_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // back: two lanes, meter hold and sticky clip, output register
    mbgm_back #(.SUM_WIDTH(SUM_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_head_valid    (q_valid),
        .i_head_left     (q_out[ITEM_W-1 -: SUM_WIDTH]),
        .i_head_right    (q_out[FLAG_W +: SUM_WIDTH]),
        .i_head_flags    (q_out[FLAG_W-1:0]),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out),
        .o_clipped       (o_clipped),
        .o_meter_valid   (o_meter_valid),
        .o_peak_left     (o_peak_left),
        .o_peak_right    (o_peak_right),
        .o_end_of_buffer (o_end_of_buffer)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// master bus gain, meter and clip unit testbench
// drives stereo frames and register writes through the block, predicts every
// result beat with a bit-exact software model and compares field by field
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic               clipped;
    logic               meter_valid;
    logic [40:0]        peak_left;
    logic [40:0]        peak_right;
    logic               eob;
} t_frame_result;

class mix_scoreboard;
    // settings mirror
    longint gain;
    longint volume;
    longint soft_mode;
    longint comp;
    longint bypass;
    longint damp;
    // meter and clip state
    int     position;
    longint blk_l;
    longint blk_r;
    longint held_l;
    longint held_r;
    bit     clip_seen;

    t_frame_result pending[$];
    int errors;

    function new();
        gain = 32768;
        volume = 100;
        soft_mode = 0;
        comp = 0;
        bypass = 0;
        damp = 64'd16777216;
        position = 0;
        blk_l = 0;
        blk_r = 0;
        held_l = 0;
        held_r = 0;
        clip_seen = 0;
        errors = 0;
    endfunction

    function void write_reg(int idx, longint value);
        longint v;
        case (idx)
            mbgm_pkg::REG_GAIN: gain = value & 64'h1ffff;
            mbgm_pkg::REG_VOLUME: begin
                volume = value & 64'h7f;
                v = ((volume * volume * volume * volume) << 24) / 64'd100000000;
                damp = (v > 64'd33554431) ? 64'd33554431 : v;
            end
            mbgm_pkg::REG_SOFT: soft_mode = value & 7;
            mbgm_pkg::REG_COMP: comp = value & 1;
            mbgm_pkg::REG_BYPASS: bypass = value & 1;
            default: ;
        endcase
    endfunction

    // gain then damp, damp truncates toward zero
    function longint apply_gain(longint v);
        longint q;
        longint r;
        longint m;
        longint p;
        bit neg;
        q = v >>> 15;
        r = v & 64'h7fff;
        v = q * gain + ((r * gain) >> 15);
        neg = v < 0;
        m = neg ? -v : v;
        p = (m >> 24) * damp + (((m & 64'hffffff) * damp) >> 24);
        return neg ? -p : p;
    endfunction

    function longint peak_mag(longint v);
        longint m;
        m = v < 0 ? -v : v;
        return (m > 64'd2199023255551) ? 64'd2199023255551 : m;
    endfunction

    function longint cubic(longint s, int k);
        longint a_tab[4];
        longint ai_tab[4];
        longint a23_tab[4];
        longint gc_tab[4];
        longint mx;
        longint a;
        longint u;
        longint x;
        longint x3;
        longint f;
        bit neg;
        a_tab = '{6081741, 4487905, 3145728, 2222981};
        ai_tab = '{2892623, 3919910, 5592405, 7913781};
        a23_tab = '{4054494, 2991937, 2097152, 1481987};
        gc_tab = '{4984564, 5917023, 8388608, 11870672};
        if (s == 0) return 0;
        neg = s < 0;
        mx = neg ? 32768 : 32767;
        a = neg ? -s : s;
        u = neg ? (a >> 8) : ((a << 22) / (64'd32767 * 64'd32768));
        x = (u * ai_tab[k]) >> 22;
        if (x < 64'd4194304) begin
            x3 = (((x * x) >> 22) * x) >> 22;
            f = (a_tab[k] * (x - x3 / 3)) >> 22;
        end else begin
            f = a23_tab[k];
        end
        if (comp != 0) f = (f * gc_tab[k]) >> 22;
        a = (f * mx) >> 7;
        return neg ? -a : a;
    endfunction

    function longint shape(longint v);
        longint s;
        longint hi;
        longint lo;
        hi = 64'd32767 * 64'd32768;
        lo = -64'd32768 * 64'd32768;
        s = v > 64'sd2147483647 ? 64'sd2147483647 :
            (v < -64'sd2147483648 ? -64'sd2147483648 : v);
        if (bypass != 0) return s;
        if (soft_mode >= 1 && soft_mode <= 4) s = cubic(s, int'(soft_mode) - 1);
        if (s > hi || s < lo) begin
            clip_seen = 1;
            s = s > 0 ? hi : lo;
        end
        return s;
    endfunction

    function longint hold_peak(longint held, longint blk);
        if (blk >= held) return blk;
        held = held >> 1;
        return held < 64'd2147484 ? 0 : held;
    endfunction

    function void note_frame(logic signed [39:0] ls, logic signed [39:0] rs, bit last);
        longint l;
        longint r;
        bit closed;
        t_frame_result e;
        l = apply_gain(longint'(ls));
        r = apply_gain(longint'(rs));
        if (position % 4 == 0) begin
            if (peak_mag(l) > blk_l) blk_l = peak_mag(l);
            if (peak_mag(r) > blk_r) blk_r = peak_mag(r);
        end
        closed = last || position >= 63;
        if (closed) begin
            held_l = hold_peak(held_l, blk_l);
            held_r = hold_peak(held_r, blk_r);
            blk_l = 0;
            blk_r = 0;
            position = 0;
        end else begin
            position++;
        end
        e.left = 32'(shape(l));
        e.right = 32'(shape(r));
        e.clipped = clip_seen;
        e.meter_valid = closed;
        e.peak_left = 41'(held_l);
        e.peak_right = 41'(held_r);
        e.eob = last;
        pending.push_back(e);
        if (last) clip_seen = 0;
    endfunction

    function void check_frame(t_frame_result got);
        t_frame_result e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat", $time);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.left !== e.left) begin
            $display("%0t: left expected %0d actual %0d", $time, e.left, got.left);
            errors++;
        end
        if (got.right !== e.right) begin
            $display("%0t: right expected %0d actual %0d", $time, e.right, got.right);
            errors++;
        end
        if (got.clipped !== e.clipped) begin
            $display("%0t: clipped expected %0b actual %0b", $time, e.clipped, got.clipped);
            errors++;
        end
        if (got.meter_valid !== e.meter_valid) begin
            $display("%0t: meter_valid expected %0b actual %0b", $time,
                     e.meter_valid, got.meter_valid);
            errors++;
        end
        if (got.peak_left !== e.peak_left) begin
            $display("%0t: peak_left expected %0d actual %0d", $time,
                     e.peak_left, got.peak_left);
            errors++;
        end
        if (got.peak_right !== e.peak_right) begin
            $display("%0t: peak_right expected %0d actual %0d", $time,
                     e.peak_right, got.peak_right);
            errors++;
        end
        if (got.eob !== e.eob) begin
            $display("%0t: end_of_buffer expected %0b actual %0b", $time, e.eob, got.eob);
            errors++;
        end
    endfunction
endclass

module testbench;
    import mbgm_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [39:0]   i_left_sum = '0;
    logic signed [39:0]   i_right_sum = '0;
    logic                 i_last_frame = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [31:0]   o_left_out;
    logic signed [31:0]   o_right_out;
    logic                 o_clipped;
    logic                 o_meter_valid;
    logic [PEAK_W-1:0]    o_peak_left;
    logic [PEAK_W-1:0]    o_peak_right;
    logic                 o_end_of_buffer;

    mix_scoreboard scoreboard = new();
    longint cycles = 0;
    bit     sink_idle_ok = 1'b1;   // random stalls on the result side
    bit     long_hold = 1'b0;      // long receiver hold-off request

    always #5 i_clk = ~i_clk;

    master_bus_gain_meter_clip_unit dut (.*);

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: checks each accepted beat
    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.left = o_left_out;
            got.right = o_right_out;
            got.clipped = o_clipped;
            got.meter_valid = o_meter_valid;
            got.peak_left = o_peak_left;
            got.peak_right = o_peak_right;
            got.eob = o_end_of_buffer;
            scoreboard.check_frame(got);
        end
    end

    // receiver readiness: bursts of stalls, plus one long hold-off
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (sink_idle_ok && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // apb write, setup then access, pready always high
    task automatic reg_write(logic [IDX_W-1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        scoreboard.write_reg(int'(idx), longint'(value));
    endtask

    // one frame beat; valid stays high between back-to-back beats
    task automatic send_frame(logic signed [39:0] l, logic signed [39:0] r, bit last,
                              bit may_idle);
        int n;
        if (may_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_sum <= l;
        i_right_sum <= r;
        i_last_frame <= last;
        @(posedge i_clk iff o_in_ready);
        scoreboard.note_frame(l, r, last);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (scoreboard.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [39:0] random_sum();
        logic signed [39:0] v;
        case ($urandom_range(0, 5))
            0: v = 40'({$urandom, $urandom});
            1: v = 40'($signed($urandom_range(0, 70000)) - 35000) <<< 15;
            2: v = $signed(40'($urandom_range(0, 2000000))) - 40'sd1000000;
            3: v = $urandom_range(0, 1) ? 40'sh7f_ffff_ffff : 40'sh80_0000_0000;
            default: v = 40'($signed($urandom)) <<< $urandom_range(0, 8);
        endcase
        return v;
    endfunction

    task automatic random_phase(int count, bit may_idle);
        for (int i = 0; i < count; i++)
            send_frame(random_sum(), random_sum(), $urandom_range(0, 40) == 0, may_idle);
    endtask

    initial begin
        logic signed [39:0] edge_vals[6];
        edge_vals = '{40'sh7f_ffff_ffff, 40'sh80_0000_0000, 40'sd0, -40'sd1,
                      40'sd1073709056, -40'sd1073741824};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, clip limits, sub-block close on last frame
        foreach (edge_vals[i])
            send_frame(edge_vals[i], edge_vals[5 - i], i == 5, 1'b0);
        for (int m = 1; m <= 4; m++) begin
            drain();
            reg_write(REG_SOFT, m);
            reg_write(REG_COMP, m[0]);
            send_frame(40'sd900000000, -40'sd2000000000, 1'b0, 1'b0);
            send_frame(40'sd1000, -40'sd500000000, 1'b1, 1'b0);
        end
        drain();
        reg_write(REG_SOFT, 7);
        reg_write(REG_BYPASS, 1);
        reg_write(REG_GAIN, 65536);
        reg_write(REG_VOLUME, 127);
        send_frame(40'sh7f_ffff_ffff, 40'sh80_0000_0000, 1'b0, 1'b0);
        send_frame(40'sd3000000000, -40'sd3000000000, 1'b1, 1'b0);

        // random settings, extremes among them
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            reg_write(REG_GAIN, ph == 0 ? 0 : (ph == 1 ? 131071 : $urandom_range(0, 65536)));
            reg_write(REG_VOLUME, ph == 2 ? 0 : (ph == 3 ? 100 : $urandom_range(0, 127)));
            reg_write(REG_SOFT, $urandom_range(0, 7));
            reg_write(REG_COMP, $urandom_range(0, 1));
            reg_write(REG_BYPASS, $urandom_range(0, 3) == 0);
            if (ph == 4) long_hold = 1'b1;   // fills the block, stalls the input
            random_phase(130, 1'b1);
        end

        // last part without idling on either side
        drain();
        reg_write(REG_BYPASS, 0);
        reg_write(REG_SOFT, 2);
        sink_idle_ok = 1'b0;
        random_phase(130, 1'b0);

        drain();
        if (scoreboard.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
